>>> src/irclt_pkg.sv
// irclt_pkg: shared types and constants for the irc line tokenizer
// no dependencies; used by irc_line_tokenizer_top

package irclt_pkg;

   localparam int MAX_FIELDS    = 64;
   localparam int IDX_W         = 6;
   localparam int FIELD_CAP_INT = (MAX_FIELDS - 1 < 63) ? MAX_FIELDS - 1 : 63;
   localparam logic [IDX_W-1:0] FIELD_CAP = IDX_W'(FIELD_CAP_INT);

   localparam logic [7:0] CH_AT    = 8'h40;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SPACE = 8'h20;

   typedef enum logic [3:0] {
      PH_START      = 4'd0,
      PH_TAGS       = 4'd1,
      PH_SKIP_LEAD  = 4'd2,
      PH_PREFIX     = 4'd3,
      PH_SKIP_CMD   = 4'd4,
      PH_COMMAND    = 4'd5,
      PH_SKIP_PARAM = 4'd6,
      PH_MIDDLE     = 4'd7,
      PH_TRAILING   = 4'd8
   } phase_type;

   typedef enum logic [2:0] {
      KIND_DROP   = 3'd0,
      KIND_KEY    = 3'd1,
      KIND_VALUE  = 3'd2,
      KIND_PREFIX = 3'd3,
      KIND_CMD    = 3'd4,
      KIND_MIDDLE = 3'd5,
      KIND_TRAIL  = 3'd6
   } kind_type;

   localparam logic [1:0] EQ_NONE = 2'd0;
   localparam logic [1:0] EQ_ONE  = 2'd1;
   localparam logic [1:0] EQ_MORE = 2'd2;

   typedef struct packed {
      logic [7:0]       out_ch;
      kind_type         kind;
      logic [IDX_W-1:0] field_index;
      logic             field_first;
      logic             end_of_line;
      logic             malformed;
   } rsp_type;

endpackage

>>> src/irc_line_tokenizer_top.sv
// irc_line_tokenizer_top: labels each byte of an irc line with its field
// depends on irclt_pkg
// each accepted word's result is registered in the output or skid register
// one word per cycle while req_tready is high; the line state updates in one step per byte
// a skid register holds one result while the output is stalled, so req_tready is registered
// reset (synchronous, active high) returns to line start and empties the output stages

module irc_line_tokenizer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // ch
   input  logic        req_tlast,   // line_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // out_ch[7:0], kind[10:8], field_index[16:11], zero fill
   output logic [1:0]  rsp_tuser,   // field_first[0], malformed[1]
   output logic        rsp_tlast    // end_of_line
);

   irclt_pkg::phase_type               phase_ff, phase_in, phase_step;
   logic [irclt_pkg::IDX_W-1:0]        idx_ff, idx_in, idx_step;
   logic [1:0]                         eq_ff, eq_in, eq_step;
   logic                               pend_ff, pend_in;

   irclt_pkg::rsp_type                 res_in;
   irclt_pkg::rsp_type                 out_ff, skid_ff;
   logic                               out_valid_ff, skid_valid_ff;
   logic                               accept;
   irclt_pkg::kind_type                kind;
   logic [irclt_pkg::IDX_W-1:0]        idx_bump;

   assign req_tready = ~skid_valid_ff;
   assign accept     = req_tvalid & req_tready;
   assign idx_bump   = (idx_ff < irclt_pkg::FIELD_CAP) ? idx_ff + 1'b1 : idx_ff;

   // next line state for the byte on the input
   always_comb begin
      phase_step = phase_ff;
      idx_step   = idx_ff;
      eq_step    = eq_ff;
      kind       = irclt_pkg::KIND_DROP;
      unique case (phase_ff)
         irclt_pkg::PH_TAGS: begin
            if (req_tdata == irclt_pkg::CH_SEMI) begin
               idx_step = idx_bump;
               eq_step  = irclt_pkg::EQ_NONE;
            end else if (req_tdata == irclt_pkg::CH_SPACE) begin
               phase_step = irclt_pkg::PH_SKIP_LEAD;
               idx_step   = '0;
               eq_step    = irclt_pkg::EQ_NONE;
            end else if (req_tdata == irclt_pkg::CH_EQ) begin
               eq_step = (eq_ff == irclt_pkg::EQ_NONE) ? irclt_pkg::EQ_ONE
                                                       : irclt_pkg::EQ_MORE;
            end else if (eq_ff == irclt_pkg::EQ_NONE) begin
               kind = irclt_pkg::KIND_KEY;
            end else if (eq_ff == irclt_pkg::EQ_ONE) begin
               kind = irclt_pkg::KIND_VALUE;
            end
         end
         irclt_pkg::PH_SKIP_LEAD: begin
            if (req_tdata == irclt_pkg::CH_COLON) begin
               phase_step = irclt_pkg::PH_PREFIX;
            end else if (req_tdata != irclt_pkg::CH_SPACE) begin
               phase_step = irclt_pkg::PH_COMMAND;
               kind       = irclt_pkg::KIND_CMD;
            end
         end
         irclt_pkg::PH_PREFIX: begin
            if (req_tdata == irclt_pkg::CH_SPACE) begin
               phase_step = irclt_pkg::PH_SKIP_CMD;
            end else begin
               kind = irclt_pkg::KIND_PREFIX;
            end
         end
         irclt_pkg::PH_SKIP_CMD: begin
            if (req_tdata != irclt_pkg::CH_SPACE) begin
               phase_step = irclt_pkg::PH_COMMAND;
               kind       = irclt_pkg::KIND_CMD;
            end
         end
         irclt_pkg::PH_COMMAND: begin
            if (req_tdata == irclt_pkg::CH_SPACE) begin
               phase_step = irclt_pkg::PH_SKIP_PARAM;
               idx_step   = '0;
            end else begin
               kind = irclt_pkg::KIND_CMD;
            end
         end
         irclt_pkg::PH_SKIP_PARAM: begin
            if (req_tdata == irclt_pkg::CH_COLON) begin
               phase_step = irclt_pkg::PH_TRAILING;
            end else if (req_tdata != irclt_pkg::CH_SPACE) begin
               phase_step = irclt_pkg::PH_MIDDLE;
               kind       = irclt_pkg::KIND_MIDDLE;
            end
         end
         irclt_pkg::PH_MIDDLE: begin
            if (req_tdata == irclt_pkg::CH_SPACE) begin
               phase_step = irclt_pkg::PH_SKIP_PARAM;
               idx_step   = idx_bump;
            end else begin
               kind = irclt_pkg::KIND_MIDDLE;
            end
         end
         irclt_pkg::PH_TRAILING: begin
            kind = irclt_pkg::KIND_TRAIL;
         end
         default: begin
            if (req_tdata == irclt_pkg::CH_AT) begin
               phase_step = irclt_pkg::PH_TAGS;
               idx_step   = '0;
               eq_step    = irclt_pkg::EQ_NONE;
            end else if (req_tdata == irclt_pkg::CH_COLON) begin
               phase_step = irclt_pkg::PH_PREFIX;
            end else if (req_tdata == irclt_pkg::CH_SPACE) begin
               phase_step = irclt_pkg::PH_SKIP_LEAD;
            end else begin
               phase_step = irclt_pkg::PH_COMMAND;
               kind       = irclt_pkg::KIND_CMD;
            end
         end
      endcase

      if (req_tlast) begin
         phase_in = irclt_pkg::PH_START;
         idx_in   = '0;
         eq_in    = irclt_pkg::EQ_NONE;
         pend_in  = 1'b1;
      end else begin
         phase_in = phase_step;
         idx_in   = idx_step;
         eq_in    = eq_step;
         pend_in  = (kind == irclt_pkg::KIND_DROP);
      end
   end

   // result word for the byte on the input
   always_comb begin
      res_in.out_ch      = req_tdata;
      res_in.kind        = kind;
      res_in.field_index = '0;
      res_in.field_first = 1'b0;
      res_in.end_of_line = req_tlast;
      res_in.malformed   = req_tlast && ((phase_step == irclt_pkg::PH_TAGS) ||
                                         (phase_step == irclt_pkg::PH_PREFIX));
      if (kind != irclt_pkg::KIND_DROP) begin
         res_in.field_first = pend_ff;
         if (kind == irclt_pkg::KIND_KEY || kind == irclt_pkg::KIND_VALUE ||
             kind == irclt_pkg::KIND_MIDDLE || kind == irclt_pkg::KIND_TRAIL) begin
            res_in.field_index = idx_step;
         end
      end
   end

   // line state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= irclt_pkg::PH_START;
         idx_ff   <= '0;
         eq_ff    <= irclt_pkg::EQ_NONE;
         pend_ff  <= 1'b1;
      end else if (accept) begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         eq_ff    <= eq_in;
         pend_ff  <= pend_in;
      end
   end

   // output register with skid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_tready) begin
         out_ff <= skid_valid_ff ? skid_ff : res_in;
      end else if (accept) begin
         skid_ff <= res_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'b0, out_ff.field_index, out_ff.kind, out_ff.out_ch};
   assign rsp_tuser  = {out_ff.malformed, out_ff.field_first};
   assign rsp_tlast  = out_ff.end_of_line;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a word while the output register is empty");

   a_mal_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> rsp_tlast)
      else $error("malformed flag away from end of line");

   a_first_labeled: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata[10:8] != irclt_pkg::KIND_DROP))
      else $error("field start on a dropped byte");

   a_line_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> (phase_ff == irclt_pkg::PH_START && pend_ff))
      else $error("line state not cleared after last byte");

endmodule
